/* design/sied_pkg.sv */
// Shared types, codes and constants of the switch interface event decoder.
`timescale 1ns / 1ps
`default_nettype none

package sied_pkg;

  // Sizing of the per-channel state store.
  localparam int NUM_INTERFACES_DEF = 16;
  localparam int CHANNELS           = 4;

  // Output fields that do not apply to an event read as all ones.
  localparam logic [7:0] NOT_APPLICABLE = 8'hFF;

  // Interface type codes.
  localparam logic [1:0] IF_SINGLE = 2'd1;
  localparam logic [1:0] IF_FOUR   = 2'd2;

  // Mode codes and range limits.
  localparam logic [3:0] MODE_PUSH_LO      = 4'd1;
  localparam logic [3:0] MODE_PUSH_HI      = 4'd3;
  localparam logic [3:0] MODE_PRES_EDGE    = 4'd4;
  localparam logic [3:0] MODE_PRES_LEVEL   = 4'd5;
  localparam logic [3:0] MODE_LIGHT_LO     = 4'd6;
  localparam logic [3:0] MODE_PRES_LVL_REG = 4'd8;
  localparam logic [3:0] MODE_PRES_HI      = 4'd9;
  localparam logic [3:0] MODE_REG_HI       = 4'd11;

  // Status flag bit positions.
  localparam int ST_SHORT     = 0;
  localparam int ST_LONG      = 1;
  localparam int ST_RELEASE   = 2;
  localparam int ST_PRESENCE  = 3;
  localparam int ST_VACANCY   = 4;
  localparam int ST_LIGHT     = 5;
  localparam int ST_SHORT_CH3 = 6;

  typedef enum logic [2:0] {
    EV_SHORT    = 3'd0,
    EV_LONG     = 3'd1,
    EV_RELEASE  = 3'd2,
    EV_PRESENCE = 3'd3,
    EV_VACANCY  = 3'd4,
    EV_LIGHT    = 3'd5
  } event_kind_t;

  // What an event does to its store entry.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SHORT,
    OP_LONG,
    OP_SHORT_LONG
  } store_op_t;

  // One input word: a wall-interface report.
  typedef struct packed {
    logic [3:0] interface_address;
    logic       active;
    logic [1:0] interface_type;
    logic [3:0] mode;
    logic [7:0] status_bits;
    logic [7:0] reading;
  } report_t;

  // One output word: a decoded event.
  typedef struct packed {
    event_kind_t event_kind;
    logic [3:0]  source_address;
    logic [1:0]  channel;
    logic [7:0]  on_position;
    logic [7:0]  rising_direction;
    logic [7:0]  light_level;
    logic        last;
  } evt_word_t;

  // Event handed from the sequencer to the store update stage.
  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  addr;
    logic [1:0]  ch;
    store_op_t   op;
    logic [7:0]  light;
    logic        last;
  } seq_evt_t;

  // Contents of one store entry.
  typedef struct packed {
    logic on;
    logic dir;
  } cell_bits_t;

endpackage

`default_nettype wire

/* design/sied_seq.sv */
// Report decoder and event sequencer: turns one report into a series of events.
`timescale 1ns / 1ps
`default_nettype none

module sied_seq #(
  parameter int NUM_INTERFACES = sied_pkg::NUM_INTERFACES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               report_valid,
  output logic                    report_stall,
  input  wire sied_pkg::report_t  report,
  input  wire logic               take,
  output logic                    issue_valid,
  output sied_pkg::seq_evt_t      issue
);
  import sied_pkg::*;

  // True when a four-channel flag set still holds an event.
  function automatic logic has_event(input logic [7:0] st, input logic [7:0] rd);
    has_event = st[ST_SHORT] | st[ST_LONG] | st[ST_RELEASE] | st[ST_SHORT_CH3] |
                st[ST_PRESENCE] | st[ST_VACANCY] | (st[ST_LIGHT] & (|rd));
  endfunction

  // Lowest set bit of a four-bit vector.
  function automatic logic [1:0] lowest(input logic [3:0] v);
    if (v[0]) begin
      lowest = 2'd0;
    end else if (v[1]) begin
      lowest = 2'd1;
    end else if (v[2]) begin
      lowest = 2'd2;
    end else begin
      lowest = 2'd3;
    end
  endfunction

  logic       a_valid;
  logic       a_four;
  logic [3:0] a_addr;
  logic [7:0] a_st;
  logic [7:0] a_rd;
  seq_evt_t   a_sev;

  logic       load;
  logic       load_events;
  logic       issue_go;
  seq_evt_t   single_ev;
  logic       single_have;
  logic       four_ok;
  logic       in_range;
  logic       pres_ok;
  logic       vac_ok;
  logic       lig_ok;
  logic [3:0] mode_in;
  logic [7:0] st_in;

  seq_evt_t   pick;
  logic [7:0] st_next;
  logic [3:0] short_bits;

  // Decode a single-channel report into its one event, and check four-channel modes.
  always_comb begin
    mode_in     = report.mode;
    st_in       = report.status_bits;
    single_have = 1'b0;
    single_ev   = '{kind: EV_SHORT, addr: report.interface_address, ch: 2'd0,
                    op: OP_NONE, light: NOT_APPLICABLE, last: 1'b1};
    pres_ok     = mode_in <= MODE_PRES_HI;
    vac_ok      = (mode_in == MODE_PRES_LEVEL) || (mode_in == MODE_PRES_LVL_REG) ||
                  (mode_in == MODE_PRES_HI);
    lig_ok      = mode_in >= MODE_LIGHT_LO;
    if (mode_in >= MODE_PUSH_LO && mode_in <= MODE_PUSH_HI) begin
      if (st_in[ST_LONG]) begin
        single_have  = 1'b1;
        single_ev.kind = EV_LONG;
        single_ev.op   = st_in[ST_SHORT] ? OP_SHORT_LONG : OP_LONG;
      end else if (st_in[ST_SHORT]) begin
        single_have  = 1'b1;
        single_ev.kind = EV_SHORT;
        single_ev.op   = OP_SHORT;
      end else if (st_in[ST_RELEASE]) begin
        single_have  = 1'b1;
        single_ev.kind = EV_RELEASE;
      end
    end else if (mode_in >= MODE_PRES_EDGE && mode_in <= MODE_REG_HI) begin
      if (lig_ok && st_in[ST_LIGHT]) begin
        single_have     = 1'b1;
        single_ev.kind  = EV_LIGHT;
        single_ev.light = report.reading;
      end else if (vac_ok && st_in[ST_VACANCY]) begin
        single_have    = 1'b1;
        single_ev.kind = EV_VACANCY;
      end else if (pres_ok && st_in[ST_PRESENCE]) begin
        single_have    = 1'b1;
        single_ev.kind = EV_PRESENCE;
      end
    end
    four_ok  = ((mode_in >= MODE_PUSH_LO && mode_in <= MODE_PUSH_HI) ||
                (mode_in == MODE_PRES_LEVEL)) && has_event(st_in, report.reading);
    in_range = 32'(report.interface_address) < NUM_INTERFACES;
    load_events = report.active && in_range &&
                  (((report.interface_type == IF_SINGLE) && single_have) ||
                   ((report.interface_type == IF_FOUR) && four_ok));
  end

  // Pick the next four-channel event by priority and clear its flag.
  always_comb begin
    short_bits = {a_st[ST_SHORT_CH3], a_st[ST_RELEASE], a_st[ST_LONG], a_st[ST_SHORT]};
    st_next    = a_st;
    pick       = '{kind: EV_SHORT, addr: a_addr, ch: 2'd0, op: OP_NONE,
                   light: NOT_APPLICABLE, last: 1'b1};
    if (|short_bits) begin
      pick.kind = EV_SHORT;
      pick.op   = OP_SHORT;
      pick.ch   = lowest(short_bits);
      case (pick.ch)
        2'd0:    st_next[ST_SHORT]     = 1'b0;
        2'd1:    st_next[ST_LONG]      = 1'b0;
        2'd2:    st_next[ST_RELEASE]   = 1'b0;
        default: st_next[ST_SHORT_CH3] = 1'b0;
      endcase
    end else if (a_st[ST_PRESENCE]) begin
      pick.kind             = EV_PRESENCE;
      st_next[ST_PRESENCE] = 1'b0;
    end else if (a_st[ST_VACANCY]) begin
      pick.kind            = EV_VACANCY;
      st_next[ST_VACANCY] = 1'b0;
    end else if (|a_rd[3:0]) begin
      pick.kind          = EV_LONG;
      pick.op            = OP_LONG;
      pick.ch            = lowest(a_rd[3:0]);
      st_next[ST_LIGHT] = 1'b0;
    end else begin
      pick.kind          = EV_RELEASE;
      pick.ch            = lowest(a_rd[7:4]);
      st_next[ST_LIGHT] = 1'b0;
    end
    pick.last = !has_event(st_next, a_rd);
  end

  // Handshake toward the report channel and the update stage.
  always_comb begin
    issue_valid  = a_valid;
    issue        = a_four ? pick : a_sev;
    issue_go     = a_valid && take;
    report_stall = a_valid && !(take && issue.last);
    load         = report_valid && !report_stall;
  end

  // Report holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (load) begin
      a_valid <= load_events;
    end else if (issue_go && issue.last) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_four <= report.interface_type == IF_FOUR;
      a_addr <= report.interface_address;
      a_st   <= report.status_bits;
      a_rd   <= report.reading;
      a_sev  <= single_ev;
    end else if (issue_go) begin
      a_st <= st_next;
    end
  end

endmodule

`default_nettype wire

/* design/switch_interface_event_decoder_unit.sv */
// Top level of the switch interface event decoder: state store and event output.
//
// Reports enter on the report channel (report_valid, report_stall, report) and decoded
// events leave on the evt channel (evt_valid, evt_stall, evt); a word moves at a rising
// edge where valid is high and stall is low. A report yields zero to seven event words,
// the final one marked by evt.last; reports that decode to nothing are dropped.
// The first event word of a report passes the sequencer's holding register and the
// update stage register before the output register. The sequencer issues one event
// per cycle unless the update stage holds; the next report is taken in the cycle its
// predecessor issues its final event. That rate is set by the state store, a memory of
// NUM_INTERFACES * 4 entries with one read port and one write port, doing one
// read-modify-write per event, with forwarding between back-to-back accesses to the
// same entry.
// Reset clears the pipeline and a written mark per entry, so every on position and
// dimming direction reads as zero afterwards; there is no clearing pass.
// With evt_valid and evt_stall both high the output register holds its word, the
// update stage holds, and report_stall rises once the sequencer holds a report.
`timescale 1ns / 1ps
`default_nettype none

module switch_interface_event_decoder_unit #(
  parameter int NUM_INTERFACES = sied_pkg::NUM_INTERFACES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                report_valid,
  output logic                     report_stall,
  input  wire sied_pkg::report_t   report,
  output logic                     evt_valid,
  input  wire logic                evt_stall,
  output sied_pkg::evt_word_t      evt
);
  import sied_pkg::*;

  localparam int DEPTH = NUM_INTERFACES * CHANNELS;
  localparam int IDX_W = $clog2(DEPTH);

  logic                 issue_valid;
  seq_evt_t             issue;
  logic                 take;
  logic                 issue_go;

  logic                 b_valid;
  seq_evt_t             b_ev;
  logic                 b_go;
  logic [IDX_W-1:0]     b_idx;
  logic [IDX_W-1:0]     r_idx;

  cell_bits_t           mem [DEPTH];
  logic [DEPTH-1:0]     written;
  cell_bits_t           rd_data;
  logic                 rd_written;
  logic                 fwd_hit;
  cell_bits_t           fwd_data;

  cell_bits_t           cur;
  cell_bits_t           after_short;
  cell_bits_t           long_in;
  cell_bits_t           after_long;
  cell_bits_t           wdata;
  logic                 we;
  logic                 is_long;
  evt_word_t            word_next;

  sied_seq #(
    .NUM_INTERFACES (NUM_INTERFACES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .take         (take),
    .issue_valid  (issue_valid),
    .issue        (issue)
  );

  // Pipeline handshake between sequencer, update stage and output register.
  always_comb begin
    b_go     = b_valid && (!evt_valid || !evt_stall);
    take     = !b_valid || b_go;
    issue_go = issue_valid && take;
    r_idx    = IDX_W'({issue.addr, issue.ch});
    b_idx    = IDX_W'({b_ev.addr, b_ev.ch});
  end

  // Store update: apply short press and long press to the current entry.
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (rd_written) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    after_short.on  = !cur.on;
    after_short.dir = cur.on;
    long_in         = (b_ev.op == OP_SHORT_LONG) ? after_short : cur;
    after_long.on   = long_in.on | long_in.dir;
    after_long.dir  = !long_in.dir;
    is_long         = (b_ev.op == OP_LONG) || (b_ev.op == OP_SHORT_LONG);
    case (b_ev.op)
      OP_SHORT:      wdata = after_short;
      OP_LONG:       wdata = after_long;
      OP_SHORT_LONG: wdata = after_long;
      default:       wdata = cur;
    endcase
    we = b_go && (b_ev.op != OP_NONE);

    word_next.event_kind       = b_ev.kind;
    word_next.source_address   = b_ev.addr;
    word_next.channel          = b_ev.ch;
    word_next.on_position      = (b_ev.op == OP_SHORT) ? {7'd0, after_short.on}
                                                        : NOT_APPLICABLE;
    word_next.rising_direction = is_long ? {7'd0, long_in.dir} : NOT_APPLICABLE;
    word_next.light_level      = b_ev.light;
    word_next.last             = b_ev.last;
  end

  // State store: read on issue, write back when the event leaves the update stage.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[b_idx] <= wdata;
    end
    if (issue_go) begin
      rd_data    <= mem[r_idx];
      rd_written <= written[r_idx];
      fwd_hit    <= we && (b_idx == r_idx);
      fwd_data   <= wdata;
    end
  end

  // Written marks: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[b_idx] <= 1'b1;
    end
  end

  // Update stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (take) begin
      b_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go) begin
      b_ev <= issue;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (b_go) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      evt <= word_next;
    end
  end

  // A held event in the update stage keeps its contents.
  a_b_hold : assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_go) |=> (b_valid && $stable(b_ev)))
    else $error("update stage lost or changed a held event");

  // The report channel only stalls while the sequencer holds a report.
  a_stall_busy : assert property (@(posedge clk) disable iff (rst)
    !issue_valid |-> !report_stall)
    else $error("report stalled with an empty sequencer");

  // Only a short press carries an on position.
  a_pos_short : assert property (@(posedge clk) disable iff (rst)
    (evt_valid && (evt.event_kind != EV_SHORT)) |-> (evt.on_position == NOT_APPLICABLE))
    else $error("on position on an event other than a short press");

  // Only a long press carries a direction.
  a_dir_long : assert property (@(posedge clk) disable iff (rst)
    (evt_valid && (evt.event_kind != EV_LONG)) |-> (evt.rising_direction == NOT_APPLICABLE))
    else $error("direction on an event other than a long press");

endmodule

`default_nettype wire

/* test/switch_interface_event_decoder_unit_tb.sv */
// Self-checking testbench for the switch interface event decoder with a built-in event predictor.
`timescale 1ns / 1ps

module switch_interface_event_decoder_unit_tb;
  import sied_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 326;
  localparam int STORE_DEPTH  = NUM_INTERFACES_DEF * CHANNELS;

  // Interface type and mode codes that the decoder ignores.
  localparam logic [1:0] IF_NONE     = 2'd0;
  localparam logic [1:0] IF_RESERVED = 2'd3;
  localparam logic [3:0] MODE_OFF    = 4'd0;
  localparam logic [3:0] MODE_UNUSED = 4'd15;

  // Status flags as byte masks.
  localparam logic [7:0] F_SHORT    = 8'(1) << ST_SHORT;
  localparam logic [7:0] F_LONG     = 8'(1) << ST_LONG;
  localparam logic [7:0] F_RELEASE  = 8'(1) << ST_RELEASE;
  localparam logic [7:0] F_PRESENCE = 8'(1) << ST_PRESENCE;
  localparam logic [7:0] F_VACANCY  = 8'(1) << ST_VACANCY;
  localparam logic [7:0] F_LIGHT    = 8'(1) << ST_LIGHT;
  localparam logic [7:0] F_CH3      = 8'(1) << ST_SHORT_CH3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      report_valid = 1'b0;
  logic      report_stall;
  report_t   report = '0;
  logic      evt_valid;
  logic      evt_stall = 1'b0;
  evt_word_t evt;

  report_t   pending_reports[$];
  evt_word_t expected_events[$];
  logic      on_store[STORE_DEPTH];
  logic      dir_store[STORE_DEPTH];
  int        errors = 0;
  int        reports_taken = 0;
  int        events_seen = 0;
  int        cycles = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  switch_interface_event_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .report_valid(report_valid),
    .report_stall(report_stall),
    .report(report),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Short press toggles the on position; direction becomes its inverse.
  function automatic logic press_short(int idx);
    on_store[idx]  = ~on_store[idx];
    dir_store[idx] = ~on_store[idx];
    return on_store[idx];
  endfunction

  // Long press may switch on first, then reports and flips the direction.
  function automatic logic press_long(int idx);
    logic d;
    if (!on_store[idx] && dir_store[idx]) on_store[idx] = 1'b1;
    d = dir_store[idx];
    dir_store[idx] = ~d;
    return d;
  endfunction

  function automatic evt_word_t make_evt(event_kind_t kind, logic [3:0] addr, logic [1:0] ch,
                                         logic [7:0] pos, logic [7:0] dir, logic [7:0] light);
    evt_word_t w;
    w.event_kind       = kind;
    w.source_address   = addr;
    w.channel          = ch;
    w.on_position      = pos;
    w.rising_direction = dir;
    w.light_level      = light;
    w.last             = 1'b0;
    return w;
  endfunction

  // Decode one accepted report into the events it should produce, updating the stores.
  task automatic decode_report(input report_t r);
    evt_word_t  evs[$];
    evt_word_t  w;
    logic [7:0] st;
    logic [7:0] rd;
    logic [3:0] md;
    logic [3:0] addr;
    int         base;
    int         ch;
    logic       have;
    logic       found;
    logic       busy;
    logic       pres;
    logic       vac;
    logic       lig;
    int         short_pos[4] = '{ST_SHORT, ST_LONG, ST_RELEASE, ST_SHORT_CH3};
    st   = r.status_bits;
    rd   = r.reading;
    md   = r.mode;
    addr = r.interface_address;
    base = addr * CHANNELS;
    have = 1'b0;
    if (!r.active) return;
    if (r.interface_type == IF_SINGLE) begin
      w = make_evt(EV_RELEASE, addr, 2'd0, NOT_APPLICABLE, NOT_APPLICABLE, NOT_APPLICABLE);
      if (md >= MODE_PUSH_LO && md <= MODE_PUSH_HI) begin
        // Release, short, long in that order; the last match is reported.
        if (st[ST_RELEASE]) have = 1'b1;
        if (st[ST_SHORT]) begin
          have = 1'b1;
          w.event_kind  = EV_SHORT;
          w.on_position = {7'd0, press_short(base)};
        end
        if (st[ST_LONG]) begin
          have = 1'b1;
          w.event_kind       = EV_LONG;
          w.rising_direction = {7'd0, press_long(base)};
          w.on_position      = NOT_APPLICABLE;
        end
      end else if (md >= MODE_PRES_EDGE && md <= MODE_REG_HI) begin
        pres = md <= MODE_PRES_HI;
        vac  = md == MODE_PRES_LEVEL || md == MODE_PRES_LVL_REG || md == MODE_PRES_HI;
        lig  = md >= MODE_LIGHT_LO;
        if (pres && st[ST_PRESENCE]) begin
          have = 1'b1;
          w.event_kind = EV_PRESENCE;
        end
        if (vac && st[ST_VACANCY]) begin
          have = 1'b1;
          w.event_kind = EV_VACANCY;
        end
        if (lig && st[ST_LIGHT]) begin
          have = 1'b1;
          w.event_kind  = EV_LIGHT;
          w.light_level = rd;
        end
      end
      if (have) evs.push_back(w);
    end else if (r.interface_type == IF_FOUR &&
                 ((md >= MODE_PUSH_LO && md <= MODE_PUSH_HI) || md == MODE_PRES_LEVEL)) begin
      // Consume flags one at a time in priority order.
      busy = 1'b1;
      while (busy) begin
        found = 1'b0;
        for (ch = 0; ch < CHANNELS && !found; ch++) begin
          if (st[short_pos[ch]]) begin
            st[short_pos[ch]] = 1'b0;
            evs.push_back(make_evt(EV_SHORT, addr, 2'(ch), {7'd0, press_short(base + ch)},
                                   NOT_APPLICABLE, NOT_APPLICABLE));
            found = 1'b1;
          end
        end
        if (!found) begin
          if (st[ST_PRESENCE]) begin
            st[ST_PRESENCE] = 1'b0;
            evs.push_back(make_evt(EV_PRESENCE, addr, 2'd0, NOT_APPLICABLE, NOT_APPLICABLE,
                                   NOT_APPLICABLE));
          end else if (st[ST_VACANCY]) begin
            st[ST_VACANCY] = 1'b0;
            evs.push_back(make_evt(EV_VACANCY, addr, 2'd0, NOT_APPLICABLE, NOT_APPLICABLE,
                                   NOT_APPLICABLE));
          end else if (st[ST_LIGHT] && rd[3:0] != 4'd0) begin
            ch = 0;
            while (!rd[ch]) ch++;
            st[ST_LIGHT] = 1'b0;
            evs.push_back(make_evt(EV_LONG, addr, 2'(ch), NOT_APPLICABLE,
                                   {7'd0, press_long(base + ch)}, NOT_APPLICABLE));
          end else if (st[ST_LIGHT] && rd[7:4] != 4'd0) begin
            ch = 0;
            while (!rd[4 + ch]) ch++;
            st[ST_LIGHT] = 1'b0;
            evs.push_back(make_evt(EV_RELEASE, addr, 2'(ch), NOT_APPLICABLE, NOT_APPLICABLE,
                                   NOT_APPLICABLE));
          end else begin
            busy = 1'b0;
          end
        end
      end
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) expected_events.push_back(evs[i]);
  endtask

  function automatic report_t mk(logic [3:0] addr, logic act, logic [1:0] ty, logic [3:0] md,
                                 logic [7:0] st, logic [7:0] rd);
    report_t r;
    r.interface_address = addr;
    r.active            = act;
    r.interface_type    = ty;
    r.mode              = md;
    r.status_bits       = st;
    r.reading           = rd;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Stimulus: directed reports first, then random ones, then wait for the drain.
  initial begin
    report_t r;
    int made;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      on_store[i]  = 1'b0;
      dir_store[i] = 1'b0;
    end
    pending_reports.push_back(mk(4'd0, 1'b0, IF_SINGLE, MODE_PUSH_LO, F_SHORT, 8'h00));
    pending_reports.push_back(mk(4'd1, 1'b1, IF_NONE, MODE_PUSH_LO, F_SHORT, 8'h00));
    pending_reports.push_back(mk(4'd1, 1'b1, IF_RESERVED, MODE_PUSH_LO, 8'hFF, 8'h00));
    pending_reports.push_back(mk(4'd0, 1'b1, IF_SINGLE, MODE_OFF, 8'hFF, 8'hFF));
    pending_reports.push_back(mk(4'd0, 1'b1, IF_SINGLE, MODE_PUSH_LO, F_SHORT, 8'h00));
    pending_reports.push_back(mk(4'd0, 1'b1, IF_SINGLE, MODE_PUSH_LO, F_SHORT, 8'h00));
    pending_reports.push_back(mk(4'd0, 1'b1, IF_SINGLE, MODE_PUSH_HI, F_LONG, 8'h00));
    pending_reports.push_back(mk(4'd0, 1'b1, IF_SINGLE, MODE_PUSH_HI, F_RELEASE, 8'h00));
    pending_reports.push_back(mk(4'd0, 1'b1, IF_SINGLE, MODE_PUSH_LO,
                                 F_SHORT | F_LONG | F_RELEASE, 8'h00));
    pending_reports.push_back(mk(4'd15, 1'b1, IF_SINGLE, MODE_PRES_EDGE, 8'hFF, 8'hFF));
    pending_reports.push_back(mk(4'd15, 1'b1, IF_SINGLE, MODE_PRES_LEVEL,
                                 F_PRESENCE | F_VACANCY, 8'h00));
    pending_reports.push_back(mk(4'd15, 1'b1, IF_SINGLE, MODE_LIGHT_LO,
                                 F_PRESENCE | F_LIGHT, 8'h00));
    pending_reports.push_back(mk(4'd15, 1'b1, IF_SINGLE, MODE_PRES_HI,
                                 F_VACANCY | F_LIGHT, 8'hFE));
    pending_reports.push_back(mk(4'd15, 1'b1, IF_SINGLE, MODE_REG_HI,
                                 F_PRESENCE | F_VACANCY, 8'h00));
    pending_reports.push_back(mk(4'd15, 1'b1, IF_SINGLE, MODE_UNUSED, 8'hFF, 8'hFF));
    // Every flag of a four-channel report at once gives the longest event burst.
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PUSH_LO, 8'hFF, 8'h0F));
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PRES_LEVEL, F_LIGHT, 8'hF0));
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PUSH_HI, F_LIGHT, 8'h80));
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PUSH_HI,
                                 F_LIGHT | F_PRESENCE, 8'h00));
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PRES_EDGE, 8'hFF, 8'hFF));
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PUSH_LO, F_LIGHT, 8'h08));
    pending_reports.push_back(mk(4'd3, 1'b1, IF_FOUR, MODE_PUSH_LO, F_CH3, 8'h00));
    pending_reports.push_back(mk(4'd3, 1'b1, IF_FOUR, MODE_PUSH_LO, 8'h80, 8'h00));
    pending_reports.push_back(mk(4'd2, 1'b1, IF_FOUR, MODE_PUSH_HI, F_LIGHT, 8'h88));

    // Mostly well-formed reports on a few hot addresses, some raw noise.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        r.interface_address = $urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                                                   : 4'($urandom_range(0, 15));
        r.active         = 1'b1;
        r.interface_type = $urandom_range(0, 1) ? IF_SINGLE : IF_FOUR;
        if (r.interface_type == IF_SINGLE) begin
          r.mode = 4'($urandom_range(MODE_PUSH_LO, MODE_REG_HI));
        end else begin
          case ($urandom_range(0, 3))
            0: r.mode = MODE_PUSH_LO;
            1: r.mode = MODE_PUSH_LO + 4'd1;
            2: r.mode = MODE_PUSH_HI;
            default: r.mode = MODE_PRES_LEVEL;
          endcase
        end
        r.status_bits = 8'($urandom_range(0, 255));
        r.reading     = 8'($urandom_range(0, 255));
      end else begin
        r = report_t'($urandom);
      end
      pending_reports.push_back(r);
      made++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_reports.size() != 0 || report_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Report driver: predicts on acceptance and offers the next word unless idling.
  always @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else begin
      if (report_valid && !report_stall) begin
        decode_report(report);
        reports_taken++;
      end
      if (!report_valid || !report_stall) begin
        if (pending_reports.size() > 0 &&
            !(($urandom_range(0, 99) < 17) && !(reports_taken >= 120 && reports_taken < 200)))
        begin
          report       <= pending_reports.pop_front();
          report_valid <= 1'b1;
        end else begin
          report_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once some events have come through.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && events_seen >= 40) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Event monitor: compares each accepted word with the oldest expected event.
  always @(posedge clk) begin
    evt_word_t want;
    if (rst) begin
      evt_stall <= 1'b0;
    end else begin
      if (evt_valid && !evt_stall) begin
        events_seen <= events_seen + 1;
        if (expected_events.size() == 0) begin
          $error("unexpected event word: kind %0d from address %0d",
                 evt.event_kind, evt.source_address);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.event_kind, evt.event_kind);
          check_field("source_address", want.source_address, evt.source_address);
          check_field("channel", want.channel, evt.channel);
          check_field("on_position", want.on_position, evt.on_position);
          check_field("rising_direction", want.rising_direction, evt.rising_direction);
          check_field("light_level", want.light_level, evt.light_level);
          check_field("last", want.last, evt.last);
        end
      end
      evt_stall <= (hold_left != 0) ||
                   (($urandom_range(0, 99) < 17) && !(events_seen >= 250 && events_seen < 400));
    end
  end

  // Watchdog against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
